// File: sv/cycle_time_converter_macros.svh
// Assertion macros shared by the cycle time converter RTL.
`ifndef CYCLE_TIME_CONVERTER_MACROS_SVH
`define CYCLE_TIME_CONVERTER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ctc_pkg.sv
// Types and constants of the cycle time converter.
package ctc_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    FUNC_CYC_TO_US  = 2'd0,
    FUNC_US_TO_CYC  = 2'd1,
    FUNC_ELAPSED    = 2'd2,
    FUNC_HAS_ELAPSED = 2'd3
  } ctc_func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_DEVICE = 2'd2
  } ctc_status_e;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned NumCells  = 32;

  localparam logic [WordWidth-1:0] UsPerSecond = 32'd1_000_000;
  localparam logic [2*WordWidth-1:0] RoundBias  = 64'd999_999;

  // One request in flight through the divider row
  typedef struct packed {
    ctc_func_e              func;
    ctc_status_e            status;
    logic [WordWidth-1:0]   elapsed;
    logic [WordWidth-1:0]   rem;
    logic [WordWidth-1:0]   lo;
  } ctc_item_t;

endpackage

// File: sv/ctc_front.sv
// Front end: scaling multiply, rounding bias and quotient range check.
module ctc_front #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  ctc_pkg::ctc_func_e     func_i,
  input  logic [31:0]            amount_i,
  input  logic [31:0]            start_count_i,
  input  logic [31:0]            current_count_i,
  input  logic [31:0]            freq_i,
  output logic                   valid_o,
  output ctc_pkg::ctc_item_t     item_o
);

  localparam logic [31:0] ElapsedMask = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic               v1_q;
  ctc_pkg::ctc_func_e func1_q;
  logic [63:0]        prod1_q;
  logic [31:0]        elapsed1_q;
  logic               dev1_q;

  logic [31:0]        mult;
  logic [31:0]        diff;
  logic [63:0]        sum;
  logic [31:0]        divisor;
  logic               ovf;
  logic               v2_q;
  ctc_pkg::ctc_item_t item2_q;
  ctc_pkg::ctc_item_t item2_d;

  // Pick the scale factor and take the wrapping counter difference
  always_comb begin
    mult = (func_i == ctc_pkg::FUNC_CYC_TO_US) ? ctc_pkg::UsPerSecond : freq_i;
    diff = (current_count_i - start_count_i) & ElapsedMask;
  end

  // Stage one: multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func1_q    <= func_i;
      prod1_q    <= 64'(amount_i) * 64'(mult);
      elapsed1_q <= diff;
      dev1_q     <= (freq_i == 32'd0) && (func_i != ctc_pkg::FUNC_ELAPSED);
    end
  end

  // Add the ceiling bias (not for cycles to microseconds) and check that the quotient fits one word
  always_comb begin
    sum     = prod1_q + ((func1_q == ctc_pkg::FUNC_CYC_TO_US) ? 64'd0 : ctc_pkg::RoundBias);
    divisor = (func1_q == ctc_pkg::FUNC_CYC_TO_US) ? freq_i : ctc_pkg::UsPerSecond;
    ovf     = (sum[63:32] >= divisor) && (func1_q != ctc_pkg::FUNC_ELAPSED);
    item2_d.func    = func1_q;
    item2_d.elapsed = elapsed1_q;
    item2_d.rem     = sum[63:32];
    item2_d.lo      = sum[31:0];
    if (dev1_q) begin
      item2_d.status = ctc_pkg::ST_DEVICE;
    end else if (ovf) begin
      item2_d.status = ctc_pkg::ST_RANGE;
    end else begin
      item2_d.status = ctc_pkg::ST_OK;
    end
  end

  // Stage two: register the dividend
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item2_q <= item2_d;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = item2_q;

endmodule

// File: sv/ctc_div_cell.sv
// One restoring division cell: produces one quotient bit per pass.
module ctc_div_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [31:0]            freq_i,
  input  logic                   valid_i,
  input  ctc_pkg::ctc_item_t     item_i,
  output logic                   valid_o,
  output ctc_pkg::ctc_item_t     item_o
);

  logic [31:0]        divisor;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic               ge;
  logic               valid_q;
  ctc_pkg::ctc_item_t item_q;
  ctc_pkg::ctc_item_t item_d;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    divisor = (item_i.func == ctc_pkg::FUNC_CYC_TO_US) ? freq_i : ctc_pkg::UsPerSecond;
    trial   = {item_i.rem, item_i.lo[31]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    item_d         = item_i;
    item_d.rem     = ge ? diff[31:0] : trial[31:0];
    item_d.lo      = {item_i.lo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: sv/cycle_time_converter.sv
// Cycle time converter: converts counter cycles and microseconds, measures elapsed time.
//
// Requests arrive on the s_axis channel: tuser carries the operation, tdata the
// amount, the start count and the current count. Every request yields exactly one
// result on the m_axis channel: tdata carries the value and the elapsed flag,
// tuser the status. The counter clock frequency is written through cfg_wr_en_i /
// cfg_wr_data_i; the user must do so only while no request is in flight, which the block does not enforce.
// From request transfer to result valid a request passes two front stages
// (scaling multiply, then rounding add and range check), a row of 32 divider cells
// that each resolve one quotient bit, and the output register.
// Throughput is one request per cycle while the row advances; every cell takes a new
// request each cycle that the row advances.
// Reset clears all valid bits and the frequency register (frequency zero means
// conversions report a device error until it is written).
// When the receiver stalls, the result holds in the output register; the row keeps
// moving while its last cell is empty and stops only when a finished result would
// otherwise be overwritten, which then drops s_axis_tready.
module cycle_time_converter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // amount[31:0], start_count[63:32], current_count[95:64]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // value[31:0], elapsed_flag[32], zero[39:33]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  `include "cycle_time_converter_macros.svh"

  localparam int unsigned Cells = ctc_pkg::NumCells;
  localparam logic [31:0] SafeLimit = 32'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);

  logic [31:0]        freq_q;
  logic               advance;
  logic               out_load;
  logic               cell_valid [Cells+1];
  ctc_pkg::ctc_item_t cell_item  [Cells+1];

  ctc_pkg::ctc_item_t last;
  ctc_pkg::ctc_status_e fin_status;
  logic [31:0]        fin_value;
  logic               fin_flag;

  logic               out_valid_q;
  logic               out_valid_d;
  logic [31:0]        out_value_q;
  logic               out_flag_q;
  ctc_pkg::ctc_status_e out_status_q;

  // Hold the frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= 32'd0;
    end else if (cfg_wr_en_i) begin
      freq_q <= cfg_wr_data_i;
    end
  end

  // Advance the row unless a finished result would be overwritten
  assign advance       = !cell_valid[Cells] || !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  ctc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .valid_i         (s_axis_tvalid),
    .func_i          (ctc_pkg::ctc_func_e'(s_axis_tuser)),
    .amount_i        (s_axis_tdata[31:0]),
    .start_count_i   (s_axis_tdata[63:32]),
    .current_count_i (s_axis_tdata[95:64]),
    .freq_i          (freq_q),
    .valid_o         (cell_valid[0]),
    .item_o          (cell_item[0])
  );

  // Row of divider cells, one quotient bit each
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    ctc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .freq_i  (freq_q),
      .valid_i (cell_valid[g]),
      .item_i  (cell_item[g]),
      .valid_o (cell_valid[g+1]),
      .item_o  (cell_item[g+1])
    );
  end

  // Finish: safe limit check, elapsed compare, zero the payload on error
  always_comb begin
    last       = cell_item[Cells];
    fin_status = last.status;
    fin_value  = 32'd0;
    fin_flag   = 1'b0;
    if ((last.status == ctc_pkg::ST_OK) && (last.func == ctc_pkg::FUNC_HAS_ELAPSED) &&
        (last.lo > SafeLimit)) begin
      fin_status = ctc_pkg::ST_RANGE;
    end
    if (fin_status == ctc_pkg::ST_OK) begin
      case (last.func)
        ctc_pkg::FUNC_CYC_TO_US,
        ctc_pkg::FUNC_US_TO_CYC: begin
          fin_value = last.lo;
        end
        ctc_pkg::FUNC_ELAPSED: begin
          fin_value = last.elapsed;
        end
        ctc_pkg::FUNC_HAS_ELAPSED: begin
          fin_value = last.elapsed;
          fin_flag  = (last.elapsed >= last.lo);
        end
        default: begin
          fin_value = 32'd0;
        end
      endcase
    end
  end

  // Output register
  assign out_load = cell_valid[Cells] && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= fin_value;
      out_flag_q   <= fin_flag;
      out_status_q <= fin_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_flag_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  // Checks
  `CTC_ASSERT_SAME(a_stall_blocks_input,
    cell_valid[Cells] && out_valid_q && !m_axis_tready, !s_axis_tready,
    "request taken while a finished result would be overwritten")

  `CTC_ASSERT_NEXT(a_hold_while_stalled,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while the receiver stalled")

  `CTC_ASSERT_SAME(a_error_zero_payload,
    m_axis_tvalid && (m_axis_tuser != ctc_pkg::ST_OK), m_axis_tdata[32:0] == 33'd0,
    "error result carries a nonzero value or flag")

  `CTC_ASSERT_SAME(a_flag_needs_ok,
    m_axis_tvalid && m_axis_tdata[32], m_axis_tuser == ctc_pkg::ST_OK,
    "elapsed flag set on a failed request")

endmodule

// File: verif/cycle_time_converter_test.sv
// Self-checking testbench for the cycle time converter: directed table, then random requests.
module cycle_time_converter_test;

  localparam int unsigned CountWidth    = 32;
  localparam int unsigned HoldOffCycles = 150;
  localparam logic [63:0] CountMask  = (64'd1 << CountWidth) - 64'd1;
  localparam logic [63:0] SafeCycles = CountMask >> 1;
  localparam logic [63:0] WordMax    = 64'hFFFF_FFFF;
  localparam logic [63:0] UsPerSec   = 64'd1_000_000;

  typedef struct packed {
    ctc_pkg::ctc_func_e func;
    logic [31:0]        amount;
    logic [31:0]        start_count;
    logic [31:0]        current_count;
  } time_request_t;

  typedef struct packed {
    logic [31:0]          value;
    logic                 elapsed_flag;
    ctc_pkg::ctc_status_e status;
  } time_result_t;

  // One directed row: optional clock write before it, then the request and,
  // where fixed is set, the result typed in by hand.
  typedef struct packed {
    logic                 set_clock;
    logic [31:0]          clock_hz;
    ctc_pkg::ctc_func_e   func;
    logic [31:0]          amount;
    logic [31:0]          start_count;
    logic [31:0]          current_count;
    logic                 fixed;
    logic [31:0]          value;
    logic                 elapsed_flag;
    ctc_pkg::ctc_status_e status;
  } directed_row_t;

  localparam directed_row_t DirectedRows [26] = '{
    // clock not yet written: conversions fail, elapsed still works
    '{1'b0, 32'd0, ctc_pkg::FUNC_CYC_TO_US, 32'd5, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_DEVICE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_US_TO_CYC, 32'd7, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_DEVICE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'd1, 32'd0, 32'd50,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_DEVICE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_ELAPSED, 32'd0, 32'd10, 32'd3,
      1'b1, 32'hFFFF_FFF9, 1'b0, ctc_pkg::ST_OK},
    // 1 MHz: one cycle per microsecond
    '{1'b1, 32'd1_000_000, ctc_pkg::FUNC_CYC_TO_US, 32'hFFFF_FFFF, 32'd0, 32'd0,
      1'b1, 32'hFFFF_FFFF, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_US_TO_CYC, 32'hFFFF_FFFF, 32'd0, 32'd0,
      1'b1, 32'hFFFF_FFFF, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF,
      1'b1, 32'h7FFF_FFFF, 1'b1, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'h8000_0000, 32'd1, 32'd2,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_RANGE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'd0, 32'd5, 32'd5,
      1'b1, 32'd0, 1'b1, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'd100, 32'd0, 32'd99,
      1'b1, 32'd99, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_ELAPSED, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
      1'b1, 32'hFFFF_FFFF, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_ELAPSED, 32'd0, 32'hFFFF_FFFF, 32'd0,
      1'b1, 32'd1, 1'b0, ctc_pkg::ST_OK},
    // fastest clock
    '{1'b1, 32'hFFFF_FFFF, ctc_pkg::FUNC_CYC_TO_US, 32'hFFFF_FFFF, 32'd0, 32'd0,
      1'b1, 32'd1_000_000, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_US_TO_CYC, 32'hFFFF_FFFF, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_RANGE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_US_TO_CYC, 32'd1, 32'd0, 32'd0,
      1'b1, 32'd4295, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_US_TO_CYC, 32'd0, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_CYC_TO_US, 32'd0, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'd1000, 32'd0, 32'h7FFF_FFFF,
      1'b0, 32'd0, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'hFFFF_FFFF, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_RANGE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'd500_000, 32'd0, 32'hFFFF_FFFF,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_RANGE},
    // slowest clock
    '{1'b1, 32'd1, ctc_pkg::FUNC_CYC_TO_US, 32'hFFFF_FFFF, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_RANGE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_CYC_TO_US, 32'd4294, 32'd0, 32'd0,
      1'b1, 32'd4294000000, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_CYC_TO_US, 32'd4295, 32'd0, 32'd0,
      1'b1, 32'd0, 1'b0, ctc_pkg::ST_RANGE},
    '{1'b0, 32'd0, ctc_pkg::FUNC_US_TO_CYC, 32'd1_000_001, 32'd0, 32'd0,
      1'b1, 32'd2, 1'b0, ctc_pkg::ST_OK},
    '{1'b0, 32'd0, ctc_pkg::FUNC_HAS_ELAPSED, 32'hFFFF_FFFF, 32'd0, 32'd4294,
      1'b1, 32'd4294, 1'b0, ctc_pkg::ST_OK},
    // odd clock value, checked by computation only
    '{1'b1, 32'h8000_0001, ctc_pkg::FUNC_CYC_TO_US, 32'h1234_5678, 32'd0, 32'd0,
      1'b0, 32'd0, 1'b0, ctc_pkg::ST_OK}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [31:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // amount[31:0], start_count[63:32], current_count[95:64]
  logic [1:0]  s_axis_tuser = '0;  // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // value[31:0], elapsed_flag[32], zero[39:33]
  logic [1:0]  m_axis_tuser;       // status[1:0]

  logic [31:0]  clock_hz = '0;
  time_result_t results_due[$];
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_off_starts = 0;
  int unsigned  hold_off_seen = 0;
  int unsigned  hold_off_left = 0;

  cycle_time_converter #(
    .COUNT_WIDTH(CountWidth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Compute the result of one request under the current clock frequency
  function automatic time_result_t convert_request(input time_request_t r);
    time_result_t res;
    logic [63:0]  amt;
    logic [63:0]  hz;
    logic [63:0]  conv;
    logic [63:0]  elapsed;
    res     = '{value: 32'd0, elapsed_flag: 1'b0, status: ctc_pkg::ST_OK};
    amt     = {32'd0, r.amount};
    hz      = {32'd0, clock_hz};
    elapsed = (({32'd0, r.current_count} & CountMask) - ({32'd0, r.start_count} & CountMask))
              & CountMask;
    if (r.func == ctc_pkg::FUNC_ELAPSED) begin
      res.value = elapsed[31:0];
    end else if (hz == 64'd0) begin
      res.status = ctc_pkg::ST_DEVICE;
    end else if (r.func == ctc_pkg::FUNC_CYC_TO_US) begin
      conv = (amt * UsPerSec) / hz;
      if (conv > WordMax) res.status = ctc_pkg::ST_RANGE;
      else res.value = conv[31:0];
    end else begin
      conv = (amt * hz + UsPerSec - 64'd1) / UsPerSec;
      if (conv > WordMax) begin
        res.status = ctc_pkg::ST_RANGE;
      end else if (r.func == ctc_pkg::FUNC_US_TO_CYC) begin
        res.value = conv[31:0];
      end else if (conv > SafeCycles) begin
        res.status = ctc_pkg::ST_RANGE;
      end else begin
        res.value        = elapsed[31:0];
        res.elapsed_flag = (elapsed >= conv);
      end
    end
    return res;
  endfunction

  // Draw a request, often near the range limits and the elapsed threshold
  function automatic time_request_t random_request();
    time_request_t r;
    logic [63:0]   hz;
    logic [63:0]   near_amt;
    logic [63:0]   need;
    logic [31:0]   gap;
    hz            = {32'd0, clock_hz};
    r.func        = ctc_pkg::ctc_func_e'($urandom_range(0, 3));
    r.start_count = $urandom;
    case ($urandom_range(0, 3))
      0: r.amount = $urandom;
      1: r.amount = $urandom_range(0, 2000);
      default: begin
        if (hz == 64'd0 || r.func == ctc_pkg::FUNC_ELAPSED) near_amt = {32'd0, $urandom};
        else if (r.func == ctc_pkg::FUNC_CYC_TO_US) near_amt = (WordMax * hz) / UsPerSec;
        else if (r.func == ctc_pkg::FUNC_US_TO_CYC) near_amt = (WordMax * UsPerSec) / hz;
        else near_amt = (SafeCycles * UsPerSec) / hz;
        near_amt = near_amt + $urandom_range(0, 6) - 64'd3;
        if (near_amt > WordMax) r.amount = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else r.amount = near_amt[31:0];
      end
    endcase
    need = ({32'd0, r.amount} * hz + UsPerSec - 64'd1) / UsPerSec;
    if ($urandom_range(0, 1) == 1 && need <= WordMax) gap = need[31:0] + $urandom_range(0, 4) - 2;
    else gap = $urandom;
    r.current_count = r.start_count + gap;
    return r;
  endfunction

  // Offer one request, hold it until the transfer, then record its result
  task automatic send_request(input time_request_t r, input time_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.current_count, r.start_count, r.amount};
    s_axis_tuser  <= r.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    results_due.push_back(want);
  endtask

  // Wait until the pipeline is empty, then write the clock frequency
  task automatic write_clock(input logic [31:0] hz);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= hz;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    clock_hz = hz;
  endtask

  // Clock frequency for each random phase, extremes included
  function automatic logic [31:0] pick_clock(input int unsigned slot);
    case (slot % 6)
      0: return $urandom_range(1_000_000, 500_000_000);
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return $urandom_range(1, 1000);
      default: return 32'd1_000_000;
    endcase
  endfunction

  // Drive result ready: long hold-off when requested, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_off_seen != hold_off_starts) begin
      hold_off_seen = hold_off_starts;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest outstanding result
  always @(posedge clk_i) begin
    time_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result value %h flag %b status %0d", $time,
                 m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tuser);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata[31:0] !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, m_axis_tdata[31:0]);
          mismatches++;
        end
        if (m_axis_tdata[32] !== want.elapsed_flag) begin
          $display("%0t: elapsed_flag expected %b actual %b", $time, want.elapsed_flag,
                   m_axis_tdata[32]);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain and report
  initial begin
    directed_row_t row;
    time_request_t req;
    time_result_t  want;
    int unsigned   count;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    send_idle_pct = 25;
    recv_idle_pct = 51;
    for (int i = 0; i < 26; i++) begin
      row = DirectedRows[i];
      if (row.set_clock) write_clock(row.clock_hz);
      req.func          = row.func;
      req.amount        = row.amount;
      req.start_count   = row.start_count;
      req.current_count = row.current_count;
      if (row.fixed) begin
        want.value        = row.value;
        want.elapsed_flag = row.elapsed_flag;
        want.status       = row.status;
      end else begin
        want = convert_request(req);
      end
      send_request(req, want);
    end

    // random phases: receiver idles more, then sender idles more, then no idling
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 51 : 0;
      recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 25 : 0;
      for (int k = 0; k < 4; k++) begin
        write_clock(pick_clock(mode * 4 + k));
        count = 28;
        if (mode == 2 && k == 0) begin
          // stall the receiver long enough to back up the whole pipeline
          hold_off_starts++;
          count = 80;
        end
        repeat (count) begin
          req = random_request();
          send_request(req, convert_request(req));
        end
      end
    end

    // drain, then give stray results time to show up
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("cycle_time_converter test passed");
    end else begin
      $display("cycle_time_converter test failed");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #4_000_000;
    $display("cycle_time_converter test failed");
    $finish;
  end

endmodule
